// File: rtl/dpq_pkg.sv
// Package: shared types and constants for the delay priority queue.
`timescale 1ns / 1ps
package dpq_pkg;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [15:0] entry_priority;
		logic [31:0]        entry_payload;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [15:0] out_priority;
		logic [31:0]        out_payload;
		logic [4:0]         entry_count;
	} result_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

// File: rtl/dpq_datapath.sv
// Datapath: row of sorted cells, fill count and result register.
`timescale 1ns / 1ps
module dpq_datapath import dpq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  ctrl_t   ctrl,
	output result_t result
);

	localparam int CW = $clog2(DEPTH + 1);

	cmd_t               cmd_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	logic [CW+4:0]      count_ext;
	logic signed [15:0] prio_q [DEPTH];
	logic [31:0]        pay_q  [DEPTH];
	logic [DEPTH-1:0]   gt;
	logic               full;
	logic               empty;
	result_t            result_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	// live cells holding a strictly higher priority than the new entry
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CW'(i) < count_q) && (prio_q[i] > cmd_q.entry_priority);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= cmd;
		end
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic               shift_up;
			logic               take_new;
			logic signed [15:0] lower_prio;
			logic [31:0]        lower_pay;
			logic signed [15:0] upper_prio;
			logic [31:0]        upper_pay;

			if (g == 0) begin : g_first
				assign shift_up   = 1'b0;
				assign lower_prio = prio_q[g];
				assign lower_pay  = pay_q[g];
			end else begin : g_rest
				assign shift_up   = gt[g-1];
				assign lower_prio = prio_q[g-1];
				assign lower_pay  = pay_q[g-1];
			end

			if (g == DEPTH - 1) begin : g_last
				assign upper_prio = prio_q[g];
				assign upper_pay  = pay_q[g];
			end else begin : g_inner
				assign upper_prio = prio_q[g+1];
				assign upper_pay  = pay_q[g+1];
			end

			assign take_new = !shift_up && (gt[g] || (count_q == CW'(g)));

			always_ff @(posedge clk) begin
				if (ctrl.execute) begin
					case (cmd_q.opcode)
						OP_PUSH: begin
							if (!full) begin
								if (shift_up) begin
									prio_q[g] <= lower_prio;
									pay_q[g]  <= lower_pay;
								end else if (take_new) begin
									prio_q[g] <= cmd_q.entry_priority;
									pay_q[g]  <= cmd_q.entry_payload;
								end
							end
						end
						OP_POP: begin
							prio_q[g] <= upper_prio;
							pay_q[g]  <= upper_pay;
						end
						OP_TICK: begin
							if (prio_q[g] != PRIO_MIN) begin
								prio_q[g] <= prio_q[g] - 16'sd1;
							end
						end
						default: ;
					endcase
				end
			end
		end
	endgenerate

	always_comb begin
		count_d = count_q;
		case (cmd_q.opcode)
			OP_PUSH: if (!full)  count_d = count_q + 1'b1;
			OP_POP:  if (!empty) count_d = count_q - 1'b1;
			default: ;
		endcase
	end

	assign count_ext = {5'b0, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.execute) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.execute) begin
			result_q.status       <= STAT_OK;
			result_q.out_priority <= '0;
			result_q.out_payload  <= '0;
			result_q.entry_count  <= count_ext[4:0];
			case (cmd_q.opcode)
				OP_PUSH: if (full) result_q.status <= STAT_FULL;
				OP_POP: begin
					if (empty) begin
						result_q.status <= STAT_EMPTY;
					end else begin
						result_q.out_priority <= prio_q[0];
						result_q.out_payload  <= pay_q[0];
					end
				end
				default: ;
			endcase
		end
	end

	assign result = result_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.execute && (cmd_q.opcode == OP_POP) && !empty
		|=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not lower fill count");

	a_tick_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.execute && (cmd_q.opcode == OP_TICK) |=> $stable(count_q))
		else $error("tick changed fill count");
`endif

endmodule

// File: rtl/dpq_ctrl.sv
// Controller: transaction sequencing state machine.
`timescale 1ns / 1ps
module dpq_ctrl import dpq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	output logic  done,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_EXEC;
			S_EXEC: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl.capture = 1'b0;
		ctrl.execute = 1'b0;
		busy         = 1'b0;
		unique case (state_q)
			S_IDLE: ctrl.capture = start;
			S_EXEC: begin
				ctrl.execute = 1'b1;
				busy         = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctrl.execute;
		end
	end

	assign done = done_q;

`ifndef SYNTHESIS
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |=> done)
		else $error("execute cycle not followed by done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE)
		else $error("done outside idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not go busy");
`endif

endmodule

// File: rtl/delay_priority_queue_core.sv
// Top level: sorted delay priority queue with push, pop and tick.
//
// One transaction is accepted at a rising edge where start is high and busy
// is low. The block is busy for the following cycle, in which every cell of
// the sorted row decides locally whether to keep, shift or load the new
// entry (push), take its neighbour (pop) or decrement with saturation (tick).
// The result is shown for exactly one cycle with done high, the cycle after
// busy; the receiver cannot stall it, so capture it then. A new transaction
// may be started in that same cycle; the block takes no new transaction
// while busy. Priorities are kept ascending; equal priorities leave in
// arrival order. A push on a full queue is refused with status full, a pop on
// an empty queue returns status empty with zero priority and payload.
// entry_count reports the fill level after the transaction (low five bits).
// No clearing pass is needed after reset: the fill count alone marks which
// cells are live.
`timescale 1ns / 1ps
module delay_priority_queue_core import dpq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	ctrl_t ctrl;

	// sequencing: capture cycle, then the execute cycle
	dpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	// cell row, fill count and registered result
	dpq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctrl   (ctrl),
		.result (result)
	);

endmodule

// File: tb/testbench.sv
// Testbench for delay_priority_queue_core: directed and random push, pop and tick traffic.
`timescale 1ns / 1ps
module testbench;
	import dpq_pkg::*;

	localparam int DEPTH = 16;
	// Opcode three has no meaning in the block; it must leave the queue alone.
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	result_t result;

	// Model of the sorted row: ascending priorities in slots 0..fill-1.
	logic signed [15:0] prio_row [DEPTH];
	logic [31:0] handle_row [DEPTH];
	int fill = 0;

	// Outcomes of accepted transactions, oldest first.
	result_t pending_outcomes [$];
	result_t want;
	int fail_count = 0;
	int cycle_count = 0;

	delay_priority_queue_core #(.DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Runaway guard: a hung handshake or a lost result ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Applies one transaction to the model and returns what the block should answer.
	// A push goes after every entry of equal or lower priority, so ties keep
	// arrival order; a tick saturates at the most negative priority, which
	// cannot disturb the ordering.
	function automatic result_t queue_outcome(cmd_t c);
		result_t r;
		int pos;
		bit found;
		r = '0;
		r.status = STAT_OK;
		case (c.opcode)
			OP_PUSH: begin
				if (fill >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					pos = fill;
					found = 1'b0;
					for (int i = 0; i < fill; i++) begin
						if (!found && prio_row[i] > c.entry_priority) begin
							pos = i;
							found = 1'b1;
						end
					end
					for (int i = fill; i > pos; i--) begin
						prio_row[i] = prio_row[i - 1];
						handle_row[i] = handle_row[i - 1];
					end
					prio_row[pos] = c.entry_priority;
					handle_row[pos] = c.entry_payload;
					fill++;
				end
			end
			OP_POP: begin
				if (fill == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.out_priority = prio_row[0];
					r.out_payload = handle_row[0];
					for (int i = 0; i + 1 < fill; i++) begin
						prio_row[i] = prio_row[i + 1];
						handle_row[i] = handle_row[i + 1];
					end
					fill--;
				end
			end
			OP_TICK: begin
				for (int i = 0; i < fill; i++)
					if (prio_row[i] != PRIO_MIN)
						prio_row[i] = prio_row[i] - 16'sd1;
			end
			default: ;
		endcase
		r.entry_count = 5'(fill);
		return r;
	endfunction

	function automatic cmd_t make_cmd(logic [1:0] op, logic signed [15:0] prio,
			logic [31:0] handle);
		cmd_t c;
		c.opcode = op;
		c.entry_priority = prio;
		c.entry_payload = handle;
		return c;
	endfunction

	// Mostly tight clusters (ties) and values at either end, with some full-range.
	function automatic logic signed [15:0] random_prio();
		int pick;
		int v;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			v = $urandom_range(0, 6) - 3;
		else if (pick < 6)
			v = PRIO_MIN + $urandom_range(0, 3);
		else if (pick < 7)
			v = 32767 - $urandom_range(0, 3);
		else
			v = $urandom;
		return 16'(v);
	endfunction

	// push_pct steers the fill level: high values drive the queue into full,
	// low values drain it into empty.
	function automatic cmd_t random_cmd(int push_pct);
		int roll;
		logic [1:0] op;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			op = OP_NONE;
		else if (roll < 16)
			op = OP_TICK;
		else if ($urandom_range(0, 99) < push_pct)
			op = OP_PUSH;
		else
			op = OP_POP;
		return make_cmd(op, random_prio(), $urandom);
	endfunction

	// Presents one transaction from the falling edge and holds it until the
	// block takes it. start is left high so back-to-back sends need no gap.
	task automatic send_cmd(input cmd_t c);
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_outcomes.push_back(queue_outcome(c));
	endtask

	task automatic idle_for(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Empty queue: pop reports empty with zeroed fields, tick and the unused
	// opcode do nothing. Fields are driven to their far ends to show they
	// are ignored.
	task automatic test_empty_queue();
		send_cmd(make_cmd(OP_POP, 16'sh7fff, 32'hffff_ffff));
		send_cmd(make_cmd(OP_TICK, PRIO_MIN, 32'h0));
		send_cmd(make_cmd(OP_NONE, 16'sh7fff, 32'hffff_ffff));
		send_cmd(make_cmd(OP_NONE, 16'sh0, 32'h0));
		idle_for(2);
	endtask

	// Extreme priorities, ties in arrival order, tick saturation at the
	// minimum, then drain past empty.
	task automatic test_extremes();
		send_cmd(make_cmd(OP_PUSH, 16'sh7fff, 32'hffff_ffff));
		send_cmd(make_cmd(OP_PUSH, PRIO_MIN, 32'h0000_0000));
		send_cmd(make_cmd(OP_PUSH, 16'sh0, 32'h0000_00a1));
		send_cmd(make_cmd(OP_PUSH, PRIO_MIN, 32'h0000_0001));
		send_cmd(make_cmd(OP_PUSH, 16'sh0, 32'h0000_00a2));
		send_cmd(make_cmd(OP_PUSH, -16'sd1, 32'h5555_aaaa));
		send_cmd(make_cmd(OP_PUSH, PRIO_MIN + 16'sd1, 32'haaaa_5555));
		send_cmd(make_cmd(OP_TICK, 16'sh0, 32'h0));
		send_cmd(make_cmd(OP_TICK, 16'sh0, 32'h0));
		send_cmd(make_cmd(OP_NONE, 16'sh7fff, 32'hffff_ffff));
		repeat (8)
			send_cmd(make_cmd(OP_POP, 16'sh0, 32'h0));
		idle_for(2);
	endtask

	// Fill to capacity, push into a full queue, then drain with the odd tick.
	task automatic test_fill_and_overflow();
		repeat (3) begin
			while (fill < DEPTH) begin
				send_cmd(make_cmd(OP_PUSH, random_prio(), $urandom));
				if ($urandom_range(0, 3) == 0)
					idle_for($urandom_range(1, 3));
			end
			repeat (2)
				send_cmd(make_cmd(OP_PUSH, random_prio(), $urandom));
			send_cmd(make_cmd(OP_TICK, random_prio(), $urandom));
			while (fill > 0) begin
				if ($urandom_range(0, 4) == 0)
					send_cmd(make_cmd(OP_TICK, random_prio(), $urandom));
				else
					send_cmd(make_cmd(OP_POP, random_prio(), $urandom));
				if ($urandom_range(0, 3) == 0)
					idle_for($urandom_range(1, 3));
			end
			send_cmd(make_cmd(OP_POP, random_prio(), $urandom));
		end
		idle_for(1);
	endtask

	// Bursts of random length separated by random gaps; the push bias is
	// re-picked now and then so the fill level sweeps between the ends.
	task automatic test_random_mix(input int n_items);
		int sent;
		int burst;
		int push_pct;
		sent = 0;
		push_pct = 60;
		while (sent < n_items) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: push_pct = 15;
					1: push_pct = 50;
					2: push_pct = 80;
					default: push_pct = 100;
				endcase
			end
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < n_items; k++) begin
				send_cmd(random_cmd(push_pct));
				sent++;
			end
			idle_for($urandom_range(0, 5));
		end
		idle_for(1);
	endtask

	// Every done cycle carries one result; it must match the oldest outcome.
	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result transaction with nothing outstanding");
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("status", 32'(want.status), 32'(result.status));
				check_field("out_priority", 32'($unsigned(want.out_priority)),
					32'($unsigned(result.out_priority)));
				check_field("out_payload", want.out_payload, result.out_payload);
				check_field("entry_count", 32'(want.entry_count),
					32'(result.entry_count));
			end
		end
	end

	initial begin
		repeat (10)
			@(negedge clk);
		arst_n <= 1'b1;
		idle_for(2);

		test_empty_queue();
		test_extremes();
		test_fill_and_overflow();
		test_random_mix(RANDOM_ITEMS);

		// Wait until every outstanding result has been checked, then let the bench run on.
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
